[hdl/acsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller package
// Beat types, operation and mode codes, field limits and the wrap step helper.
// ----------------------------------------------------------------------------
package acsc_pkg;

  localparam logic [2:0] OP_MODE   = 3'd0;
  localparam logic [2:0] OP_NEXT   = 3'd1;
  localparam logic [2:0] OP_INC    = 3'd2;
  localparam logic [2:0] OP_DEC    = 3'd3;
  localparam logic [2:0] OP_TOGGLE = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [1:0] MODE_VIEW  = 2'd0;
  localparam logic [1:0] MODE_TIME  = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  localparam logic [2:0] FLD_HOUR   = 3'd0;
  localparam logic [2:0] FLD_MINUTE = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_MONTH  = 3'd3;
  localparam logic [2:0] FLD_YEAR   = 3'd4;

  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] DAY_MAX    = 7'd31;
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [6:0] ZERO_MIN   = 7'd0;
  localparam logic [6:0] ONE_MIN    = 7'd1;

  localparam logic [4:0] ALARM_HOUR_RST   = 5'd12;
  localparam logic [5:0] ALARM_MINUTE_RST = 6'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] now_hours;
    logic [5:0] now_minutes;
  } acsc_in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] field;
    logic       alarm_on;
    logic       commit;
    logic [4:0] set_hours;
    logic [5:0] set_minutes;
    logic [4:0] set_day;
    logic [3:0] set_month;
    logic [6:0] set_year;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       ring;
  } acsc_out_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] field;
    logic       alarm_en;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic [4:0] edit_day;
    logic [3:0] edit_month;
    logic [6:0] edit_year;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
  } acsc_state_t;

  // Steps a value up or down inside lo..hi with wrap; out-of-range values
  // land on lo going up and on hi going down.
  function automatic logic [6:0] step_val(logic [6:0] v, logic [6:0] lo,
                                          logic [6:0] hi, logic inc);
    logic [6:0] r;
    if (inc) begin
      r = (v >= hi) ? lo : v + 7'd1;
    end else begin
      r = (v <= lo || v > hi) ? hi : v - 7'd1;
    end
    return r;
  endfunction

endpackage

[hdl/alarm_clock_set_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller
// Mode, field selection, date and time editing, alarm setting and alarm match.
// ----------------------------------------------------------------------------
// Each input beat is one debounced button event or one clock tick; each
// accepted beat produces exactly one result beat carrying the full state
// after the event, plus the commit and ring strobes.
// Input channel: in_valid_i, in_stall_o, in_data_i. Output channel:
// out_valid_o, out_stall_i, out_data_o.
// The state register and, unless the output stalls, the output register load
// at the same edge the input beat is accepted. One beat is taken every cycle
// while in_stall_o is low; the rate is set by the state update loop.
// When the receiver stalls, the result holds in the output register and one
// further beat is taken into a skid entry; input stall rises only while that
// entry is occupied.
// Reset puts the block in view mode, field zero, alarm off, edit values zero
// and the alarm at 12:05, with both channels empty.
// ----------------------------------------------------------------------------
module alarm_clock_set_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acsc_pkg::acsc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acsc_pkg::acsc_out_t out_data_o
);

  acsc_pkg::acsc_state_t state_q, state_d;
  acsc_pkg::acsc_out_t   result;
  logic                  in_acc;

  assign in_acc = in_valid_i & ~in_stall_o;

  acsc_next_state u_next (
    .state_i  (state_q),
    .item_i   (in_data_i),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= acsc_pkg::MODE_VIEW;
      state_q.field        <= acsc_pkg::FLD_HOUR;
      state_q.alarm_en     <= 1'b0;
      state_q.edit_hours   <= '0;
      state_q.edit_minutes <= '0;
      state_q.edit_day     <= '0;
      state_q.edit_month   <= '0;
      state_q.edit_year    <= '0;
      state_q.alarm_hour   <= acsc_pkg::ALARM_HOUR_RST;
      state_q.alarm_minute <= acsc_pkg::ALARM_MINUTE_RST;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  acsc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/acsc_next_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller next state
// Applies one event to the current state and forms the result beat.
// ----------------------------------------------------------------------------
module acsc_next_state (
  input  acsc_pkg::acsc_state_t state_i,
  input  acsc_pkg::acsc_in_t    item_i,
  output acsc_pkg::acsc_state_t state_o,
  output acsc_pkg::acsc_out_t   result_o
);

  acsc_pkg::acsc_state_t s;
  logic                  commit;
  logic                  ring;
  logic                  inc;

  always_comb begin
    s      = state_i;
    commit = 1'b0;
    ring   = 1'b0;
    inc    = (item_i.op == acsc_pkg::OP_INC);
    unique case (item_i.op)
      acsc_pkg::OP_MODE: begin
        s.mode = (state_i.mode >= acsc_pkg::MODE_ALARM) ? acsc_pkg::MODE_VIEW
                                                        : state_i.mode + 2'd1;
        if (s.mode != acsc_pkg::MODE_VIEW) begin
          s.field = acsc_pkg::FLD_HOUR;
        end
      end
      acsc_pkg::OP_NEXT: begin
        if (state_i.mode == acsc_pkg::MODE_TIME) begin
          if (state_i.field >= acsc_pkg::FLD_YEAR) begin
            s.field = acsc_pkg::FLD_HOUR;
            commit  = 1'b1;
          end else begin
            s.field = state_i.field + 3'd1;
          end
        end else if (state_i.mode == acsc_pkg::MODE_ALARM) begin
          s.field = (state_i.field >= acsc_pkg::FLD_MINUTE) ? acsc_pkg::FLD_HOUR
                                                            : acsc_pkg::FLD_MINUTE;
        end
      end
      acsc_pkg::OP_INC, acsc_pkg::OP_DEC: begin
        if (state_i.mode == acsc_pkg::MODE_TIME) begin
          case (state_i.field)
            acsc_pkg::FLD_HOUR: s.edit_hours = 5'(acsc_pkg::step_val(
                {2'b00, state_i.edit_hours}, acsc_pkg::ZERO_MIN, acsc_pkg::HOUR_MAX, inc));
            acsc_pkg::FLD_MINUTE: s.edit_minutes = 6'(acsc_pkg::step_val(
                {1'b0, state_i.edit_minutes}, acsc_pkg::ZERO_MIN, acsc_pkg::MINUTE_MAX, inc));
            acsc_pkg::FLD_DAY: s.edit_day = 5'(acsc_pkg::step_val(
                {2'b00, state_i.edit_day}, acsc_pkg::ONE_MIN, acsc_pkg::DAY_MAX, inc));
            acsc_pkg::FLD_MONTH: s.edit_month = 4'(acsc_pkg::step_val(
                {3'b000, state_i.edit_month}, acsc_pkg::ONE_MIN, acsc_pkg::MONTH_MAX, inc));
            acsc_pkg::FLD_YEAR: s.edit_year = acsc_pkg::step_val(
                state_i.edit_year, acsc_pkg::ONE_MIN, acsc_pkg::YEAR_MAX, inc);
            default: ;
          endcase
        end else if (state_i.mode == acsc_pkg::MODE_ALARM) begin
          if (state_i.field == acsc_pkg::FLD_HOUR) begin
            s.alarm_hour = 5'(acsc_pkg::step_val({2'b00, state_i.alarm_hour},
                acsc_pkg::ZERO_MIN, acsc_pkg::HOUR_MAX, inc));
          end else if (state_i.field == acsc_pkg::FLD_MINUTE) begin
            s.alarm_minute = 6'(acsc_pkg::step_val({1'b0, state_i.alarm_minute},
                acsc_pkg::ZERO_MIN, acsc_pkg::MINUTE_MAX, inc));
          end
        end
      end
      acsc_pkg::OP_TOGGLE: begin
        if (state_i.mode == acsc_pkg::MODE_VIEW || state_i.mode == acsc_pkg::MODE_ALARM) begin
          s.alarm_en = ~state_i.alarm_en;
        end
      end
      acsc_pkg::OP_TICK: begin
        ring = state_i.alarm_en && (state_i.alarm_hour == item_i.now_hours) &&
               (state_i.alarm_minute == item_i.now_minutes);
      end
      default: ;
    endcase
  end

  assign state_o = s;

  always_comb begin
    result_o.mode         = s.mode;
    result_o.field        = s.field;
    result_o.alarm_on     = s.alarm_en;
    result_o.commit       = commit;
    result_o.set_hours    = s.edit_hours;
    result_o.set_minutes  = s.edit_minutes;
    result_o.set_day      = s.edit_day;
    result_o.set_month    = s.edit_month;
    result_o.set_year     = s.edit_year;
    result_o.alarm_hour   = s.alarm_hour;
    result_o.alarm_minute = s.alarm_minute;
    result_o.ring         = ring;
  end

endmodule

[hdl/acsc_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller output buffer
// Output register with one skid entry so a stalled result does not block input.
// ----------------------------------------------------------------------------
module acsc_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acsc_pkg::acsc_out_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acsc_pkg::acsc_out_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  acsc_pkg::acsc_out_t out_data_q, out_data_d;
  acsc_pkg::acsc_out_t skid_data_q, skid_data_d;
  logic                in_acc;
  logic                out_free;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_acc;
        if (in_acc) begin
          out_data_d = in_data_i;
        end
      end
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/acsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module acsc_assertions (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input acsc_pkg::acsc_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input acsc_pkg::acsc_out_t out_data_o
);

  // A commit only comes from wrapping past the year in date and time mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.commit |->
      out_data_o.mode == acsc_pkg::MODE_TIME && out_data_o.field == acsc_pkg::FLD_HOUR)
    else $error("commit outside of a year wrap");

  // Ringing needs an enabled alarm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ring |-> out_data_o.alarm_on)
    else $error("ring with alarm disabled");

  // The input only stalls while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Mode and field stay within their legal codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.mode <= acsc_pkg::MODE_ALARM &&
      out_data_o.field <= acsc_pkg::FLD_YEAR)
    else $error("mode or field out of range");

endmodule

bind alarm_clock_set_controller acsc_assertions u_acsc_assertions (.*);

[test/acsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller checker
// Watches both channels of the controller. Each accepted input beat goes
// through a shadow copy of the mode, field, edit and alarm state. The status
// that beat should produce is queued. Each accepted result beat is compared
// field by field with the oldest queued status, and every difference is
// counted.
// ----------------------------------------------------------------------------
module acsc_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  acsc_pkg::acsc_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  acsc_pkg::acsc_out_t out_data_i,
  output int                  mismatch_count_o,
  output int                  pending_count_o,
  output logic [4:0]          alarm_hour_o,
  output logic [5:0]          alarm_minute_o
);

  acsc_pkg::acsc_state_t shadow;
  acsc_pkg::acsc_out_t   expected_status_q[$];

  function automatic logic [6:0] bump(logic [6:0] v, logic [6:0] lo, logic [6:0] hi,
                                      logic inc);
    if (inc) begin
      if (v >= hi || v + 7'd1 < lo) return lo;
      return v + 7'd1;
    end
    if (v <= lo || v > hi) return hi;
    return v - 7'd1;
  endfunction

  function automatic void adjust_selected(logic inc);
    if (shadow.mode == acsc_pkg::MODE_TIME) begin
      case (shadow.field)
        acsc_pkg::FLD_HOUR: begin
          shadow.edit_hours = 5'(bump({2'b00, shadow.edit_hours}, acsc_pkg::ZERO_MIN,
                                      acsc_pkg::HOUR_MAX, inc));
        end
        acsc_pkg::FLD_MINUTE: begin
          shadow.edit_minutes = 6'(bump({1'b0, shadow.edit_minutes}, acsc_pkg::ZERO_MIN,
                                        acsc_pkg::MINUTE_MAX, inc));
        end
        acsc_pkg::FLD_DAY: begin
          shadow.edit_day = 5'(bump({2'b00, shadow.edit_day}, acsc_pkg::ONE_MIN,
                                    acsc_pkg::DAY_MAX, inc));
        end
        acsc_pkg::FLD_MONTH: begin
          shadow.edit_month = 4'(bump({3'b000, shadow.edit_month}, acsc_pkg::ONE_MIN,
                                      acsc_pkg::MONTH_MAX, inc));
        end
        acsc_pkg::FLD_YEAR: begin
          shadow.edit_year = bump(shadow.edit_year, acsc_pkg::ONE_MIN,
                                  acsc_pkg::YEAR_MAX, inc);
        end
        default: begin
        end
      endcase
    end else if (shadow.mode == acsc_pkg::MODE_ALARM) begin
      if (shadow.field == acsc_pkg::FLD_HOUR) begin
        shadow.alarm_hour = 5'(bump({2'b00, shadow.alarm_hour}, acsc_pkg::ZERO_MIN,
                                    acsc_pkg::HOUR_MAX, inc));
      end else if (shadow.field == acsc_pkg::FLD_MINUTE) begin
        shadow.alarm_minute = 6'(bump({1'b0, shadow.alarm_minute}, acsc_pkg::ZERO_MIN,
                                      acsc_pkg::MINUTE_MAX, inc));
      end
    end
  endfunction

  function automatic acsc_pkg::acsc_out_t next_clock_status(acsc_pkg::acsc_in_t beat);
    acsc_pkg::acsc_out_t res;
    logic                commit;
    logic                ring;
    commit = 1'b0;
    ring   = 1'b0;
    case (beat.op)
      acsc_pkg::OP_MODE: begin
        shadow.mode = (shadow.mode >= acsc_pkg::MODE_ALARM) ? acsc_pkg::MODE_VIEW
                                                            : shadow.mode + 2'd1;
        if (shadow.mode != acsc_pkg::MODE_VIEW) shadow.field = acsc_pkg::FLD_HOUR;
      end
      acsc_pkg::OP_NEXT: begin
        if (shadow.mode == acsc_pkg::MODE_TIME) begin
          if (shadow.field >= acsc_pkg::FLD_YEAR) begin
            shadow.field = acsc_pkg::FLD_HOUR;
            commit       = 1'b1;
          end else begin
            shadow.field = shadow.field + 3'd1;
          end
        end else if (shadow.mode == acsc_pkg::MODE_ALARM) begin
          shadow.field = (shadow.field >= acsc_pkg::FLD_MINUTE) ? acsc_pkg::FLD_HOUR
                                                                : acsc_pkg::FLD_MINUTE;
        end
      end
      acsc_pkg::OP_INC: adjust_selected(1'b1);
      acsc_pkg::OP_DEC: adjust_selected(1'b0);
      acsc_pkg::OP_TOGGLE: begin
        if (shadow.mode == acsc_pkg::MODE_VIEW || shadow.mode == acsc_pkg::MODE_ALARM) begin
          shadow.alarm_en = ~shadow.alarm_en;
        end
      end
      acsc_pkg::OP_TICK: begin
        ring = shadow.alarm_en && shadow.alarm_hour == beat.now_hours &&
               shadow.alarm_minute == beat.now_minutes;
      end
      default: begin
      end
    endcase
    res.mode         = shadow.mode;
    res.field        = shadow.field;
    res.alarm_on     = shadow.alarm_en;
    res.commit       = commit;
    res.set_hours    = shadow.edit_hours;
    res.set_minutes  = shadow.edit_minutes;
    res.set_day      = shadow.edit_day;
    res.set_month    = shadow.edit_month;
    res.set_year     = shadow.edit_year;
    res.alarm_hour   = shadow.alarm_hour;
    res.alarm_minute = shadow.alarm_minute;
    res.ring         = ring;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic compare_status(acsc_pkg::acsc_out_t got, acsc_pkg::acsc_out_t want);
    if (got.mode !== want.mode) report_mismatch("mode", int'(got.mode), int'(want.mode));
    if (got.field !== want.field) begin
      report_mismatch("field", int'(got.field), int'(want.field));
    end
    if (got.alarm_on !== want.alarm_on) begin
      report_mismatch("alarm_on", int'(got.alarm_on), int'(want.alarm_on));
    end
    if (got.commit !== want.commit) begin
      report_mismatch("commit", int'(got.commit), int'(want.commit));
    end
    if (got.set_hours !== want.set_hours) begin
      report_mismatch("set_hours", int'(got.set_hours), int'(want.set_hours));
    end
    if (got.set_minutes !== want.set_minutes) begin
      report_mismatch("set_minutes", int'(got.set_minutes), int'(want.set_minutes));
    end
    if (got.set_day !== want.set_day) begin
      report_mismatch("set_day", int'(got.set_day), int'(want.set_day));
    end
    if (got.set_month !== want.set_month) begin
      report_mismatch("set_month", int'(got.set_month), int'(want.set_month));
    end
    if (got.set_year !== want.set_year) begin
      report_mismatch("set_year", int'(got.set_year), int'(want.set_year));
    end
    if (got.alarm_hour !== want.alarm_hour) begin
      report_mismatch("alarm_hour", int'(got.alarm_hour), int'(want.alarm_hour));
    end
    if (got.alarm_minute !== want.alarm_minute) begin
      report_mismatch("alarm_minute", int'(got.alarm_minute), int'(want.alarm_minute));
    end
    if (got.ring !== want.ring) report_mismatch("ring", int'(got.ring), int'(want.ring));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow              = '0;
      shadow.alarm_hour   = acsc_pkg::ALARM_HOUR_RST;
      shadow.alarm_minute = acsc_pkg::ALARM_MINUTE_RST;
      mismatch_count_o    = 0;
      expected_status_q.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          compare_status(out_data_i, expected_status_q.pop_front());
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        expected_status_q.push_back(next_clock_status(in_data_i));
      end
    end
    pending_count_o <= expected_status_q.size();
    alarm_hour_o    <= shadow.alarm_hour;
    alarm_minute_o  <= shadow.alarm_minute;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm clock set controller testbench
// Drives a directed walk through every button and mode, then random button
// bursts and clock ticks, with random idling on both channels, a stretch
// with no idling and one long receiver hold-off. A checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RANDOM_BEATS = 1200;
  localparam int          IDLE_PCT     = 35;
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  acsc_pkg::acsc_in_t  in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  acsc_pkg::acsc_out_t out_data_o;
  logic                quiet       = 1'b0;
  logic                hold_go     = 1'b0;
  int                  mismatches;
  int                  pending;
  logic [4:0]          hint_hour;
  logic [5:0]          hint_minute;
  int unsigned         cycles      = 0;
  int                  sent        = 0;

  always #2 clk_i = ~clk_i;

  alarm_clock_set_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  acsc_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .alarm_hour_o     (hint_hour),
    .alarm_minute_o   (hint_minute)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : receiver
    int held;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        held = 0;
        while (held < HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
          held++;
        end
        while (hold_go) @(posedge clk_i);
      end
      out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic acsc_pkg::acsc_in_t make_beat(logic [2:0] op, int hours, int minutes);
    acsc_pkg::acsc_in_t b;
    b.op          = op;
    b.now_hours   = 5'(hours);
    b.now_minutes = 6'(minutes);
    return b;
  endfunction

  function automatic acsc_pkg::acsc_in_t tick_beat();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return make_beat(acsc_pkg::OP_TICK, int'(hint_hour), int'(hint_minute));
    if (pick < 9) begin
      return make_beat(acsc_pkg::OP_TICK, $urandom_range(23), $urandom_range(59));
    end
    return make_beat(acsc_pkg::OP_TICK, $urandom, $urandom);
  endfunction

  task automatic send_beat(acsc_pkg::acsc_in_t b);
    if (sent == 300) quiet <= 1'b1;
    if (sent == 500) quiet <= 1'b0;
    if (sent == 700) hold_go <= 1'b1;
    if (sent == 701) hold_go <= 1'b0;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  initial begin : stimulus
    acsc_pkg::acsc_in_t directed[$];
    logic [2:0]         burst_op;
    int                 burst_len;
    int                 kind;
    int                 r;

    // View mode: alarm off, then on and matching, then the time extremes.
    directed.push_back(make_beat(acsc_pkg::OP_TICK, 12, 5));
    directed.push_back(make_beat(acsc_pkg::OP_TOGGLE, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_TICK, 12, 5));
    directed.push_back(make_beat(acsc_pkg::OP_TICK, 23, 59));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 31, 63));
    directed.push_back(make_beat(acsc_pkg::OP_INC, 0, 0));
    // Time and date editing, including the zero day, month and year.
    directed.push_back(make_beat(acsc_pkg::OP_MODE, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_DEC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_INC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_DEC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_INC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_DEC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_DEC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_TOGGLE, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_DEC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_INC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    // Alarm setting, field wrap, toggle and the unused codes.
    directed.push_back(make_beat(acsc_pkg::OP_MODE, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_DEC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_INC, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_NEXT, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_TOGGLE, 0, 0));
    directed.push_back(make_beat(OP_SPARE_LO, 31, 63));
    directed.push_back(make_beat(OP_SPARE_HI, 0, 0));
    directed.push_back(make_beat(acsc_pkg::OP_MODE, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_beat(directed[i]);

    while (sent < RANDOM_BEATS + directed.size()) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        r         = $urandom_range(2);
        burst_op  = (r == 0) ? acsc_pkg::OP_NEXT : (r == 1) ? acsc_pkg::OP_INC
                                                            : acsc_pkg::OP_DEC;
        burst_len = $urandom_range(2, 70);
        repeat (burst_len) send_beat(make_beat(burst_op, $urandom, $urandom));
      end else if (kind < 40) begin
        send_beat(tick_beat());
      end else begin
        r = $urandom_range(99);
        if (r < 16) send_beat(make_beat(acsc_pkg::OP_MODE, $urandom, $urandom));
        else if (r < 34) send_beat(make_beat(acsc_pkg::OP_NEXT, $urandom, $urandom));
        else if (r < 52) send_beat(make_beat(acsc_pkg::OP_INC, $urandom, $urandom));
        else if (r < 68) send_beat(make_beat(acsc_pkg::OP_DEC, $urandom, $urandom));
        else if (r < 82) send_beat(make_beat(acsc_pkg::OP_TOGGLE, $urandom, $urandom));
        else if (r < 95) send_beat(tick_beat());
        else send_beat(make_beat(3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI))),
                                 $urandom, $urandom));
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
